@@ hw/rtl/scfr_pkg.sv @@
// Package for the COBS frame receiver: configuration register map, shared
// types, controller states, command and status bundles, and a helper function.
// No dependencies.
package scfr_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int MAX_START_DEF   = 4;

    // Fixed field widths.
    localparam int PAT_W   = 32;
    localparam int SLEN_W  = 3;
    localparam int PLEN_W  = 6;
    localparam int POS_W   = 5;
    localparam int CFG_AW  = 4;
    localparam int APB_DW  = 32;

    // Smallest decoded message length that the receiver accepts.
    localparam int MIN_PAYLOAD = 2;

    // Number of start sequence bytes held in the pattern register.
    localparam int PAT_BYTES = PAT_W / 8;

    // Frame delimiter and the COBS code that carries no implied zero.
    localparam logic [7:0] FRAME_DELIM   = 8'h00;
    localparam logic [7:0] COBS_MAX_CODE = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_START_PATTERN,
        REG_START_LENGTH,
        REG_PAYLOAD_LENGTH,
        REG_CHECKSUM_ENABLE
    } scfr_reg_t;

    // Configuration register contents.
    typedef struct packed {
        logic [PAT_W-1:0]  start_pattern;
        logic [SLEN_W-1:0] start_length;
        logic [PLEN_W-1:0] payload_length;
        logic              checksum_enable;
    } scfr_cfg_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_RECV,
        ST_SUM_RD,
        ST_SUM_USE,
        ST_EMIT_RD,
        ST_EMIT_USE,
        ST_TAIL
    } scfr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic walk_init;
        logic ok_load;
        logic step;
        logic sum_pass;
        logic tail_emit;
    } scfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_good;
        logic walk_done;
        logic w_full;
        logic emit_pending;
        logic out_free;
    } scfr_stat_t;

    // Start sequence byte k; bytes past the pattern register read as zero.
    function automatic logic [7:0] start_byte(input logic [PAT_W-1:0] pat, input int k);
        logic [7:0] b;
        b = 8'h00;
        for (int i = 0; i < PAT_BYTES; i++) begin
            if (k == i) begin
                b = pat[8*i +: 8];
            end
        end
        return b;
    endfunction

endpackage

@@ hw/rtl/scfr_if.sv @@
// Stream interfaces for the COBS frame receiver: raw byte input and decoded
// message output, each with valid/ready handshake. Depends on scfr_pkg.
interface scfr_rx_if import scfr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_msg_if import scfr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [7:0]       msg_byte;
    logic [POS_W-1:0] byte_position;
    logic             final_byte;
    logic             frame_ok;

    modport source (
        output valid, output msg_byte, output byte_position,
        output final_byte, output frame_ok, input ready
    );
    modport sink (
        input valid, input msg_byte, input byte_position,
        input final_byte, input frame_ok, output ready
    );
endinterface

@@ hw/rtl/serial_cobs_frame_receiver_top.sv @@
// Top level of the COBS frame receiver with start-sequence header.
// Depends on scfr_pkg, scfr_if, scfr_cfg, scfr_ctrl and scfr_dp.
//
//   Port    | Kind          | Direction | Payload
//   --------+---------------+-----------+----------------------------------------
//   rx      | valid/ready   | in        | rx_byte
//   msg     | valid/ready   | out       | msg_byte, byte_position, final_byte,
//           |               |           | frame_ok
//   apb     | APB write/rd  | in        | start_pattern, start_length,
//           |               |           | payload_length, checksum_enable
//
// One raw byte is taken per cycle while hunting and collecting.
// A closing delimiter starts the decode: a checksum pass over the encoded
// positions (up to len + 1: the overhead byte, then one frame store read each),
// then an emit pass over the same positions and a zero-padded tail byte for each
// message position not reached; rx stays not ready until the tail is done.
// rst_n is asynchronous; the frame store is not cleared by reset.
// A stalled consumer holds the emit pass; the last result waits in the output
// register while reception of the next frame goes on.
module serial_cobs_frame_receiver_top import scfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int MAX_START   = MAX_START_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    scfr_rx_if.sink           rx,
    scfr_msg_if.source        msg,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    scfr_cfg_t  cfg;
    scfr_cmd_t  cmd;
    scfr_stat_t stat;

    // Configuration registers.
    scfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    scfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hunt, store, decode and output.
    scfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_START   (MAX_START)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (rx.rx_byte),
        .out_valid (msg.valid),
        .out_ready (msg.ready),
        .out_byte  (msg.msg_byte),
        .out_pos   (msg.byte_position),
        .out_final (msg.final_byte),
        .out_ok    (msg.frame_ok)
    );

endmodule

@@ hw/rtl/scfr_cfg.sv @@
// APB configuration registers of the COBS frame receiver.
// Depends on scfr_pkg for the register map and the configuration struct.
module scfr_cfg import scfr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output scfr_cfg_t         cfg
);

    scfr_cfg_t cfg_reg;
    scfr_cfg_t cfg_next;
    scfr_reg_t reg_idx;
    logic      wr_en;

    // Registers sit on word boundaries.
    assign reg_idx = scfr_reg_t'(paddr[CFG_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_START_PATTERN:   cfg_next.start_pattern   = pwdata[PAT_W-1:0];
                REG_START_LENGTH:    cfg_next.start_length    = pwdata[SLEN_W-1:0];
                REG_PAYLOAD_LENGTH:  cfg_next.payload_length  = pwdata[PLEN_W-1:0];
                REG_CHECKSUM_ENABLE: cfg_next.checksum_enable = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_pattern   <= '0;
            cfg_reg.start_length    <= '0;
            cfg_reg.payload_length  <= PLEN_W'(MAX_PAYLOAD_DEF);
            cfg_reg.checksum_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_START_PATTERN:   prdata = APB_DW'(cfg_reg.start_pattern);
            REG_START_LENGTH:    prdata = APB_DW'(cfg_reg.start_length);
            REG_PAYLOAD_LENGTH:  prdata = APB_DW'(cfg_reg.payload_length);
            REG_CHECKSUM_ENABLE: prdata = APB_DW'(cfg_reg.checksum_enable);
            default:             prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/scfr_ctrl.sv @@
// Controller of the COBS frame receiver: sequences byte reception, the
// checksum pass, the emit pass and the zero tail. Depends on scfr_pkg.
module scfr_ctrl import scfr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  scfr_stat_t stat,
    output scfr_cmd_t  cmd
);

    scfr_state_t state_reg;
    scfr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_RECV:
            begin
                // Take raw bytes; a good closing delimiter starts decoding.
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && stat.frame_good)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_SUM_RD;
                end
            end
            ST_SUM_RD:
            begin
                // Checksum pass finished: latch the verdict and rewind.
                if (stat.walk_done || stat.w_full)
                begin
                    cmd.ok_load   = 1'b1;
                    cmd.walk_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_SUM_USE;
                end
            end
            ST_SUM_USE:
            begin
                cmd.step     = 1'b1;
                cmd.sum_pass = 1'b1;
                state_next   = ST_SUM_RD;
            end
            ST_EMIT_RD:
            begin
                if (stat.walk_done || stat.w_full)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_EMIT_USE;
                end
            end
            ST_EMIT_USE:
            begin
                // Hold the step while a decoded byte waits for the output.
                if (!stat.emit_pending || stat.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_TAIL:
            begin
                // Pad message positions that the decode never reached.
                if (stat.w_full)
                begin
                    state_next = ST_RECV;
                end
                else if (stat.out_free)
                begin
                    cmd.tail_emit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule

@@ hw/rtl/scfr_dp.sv @@
// Datapath of the COBS frame receiver: start sequence hunt, frame store,
// COBS decode walker, checksum and output register. Depends on scfr_pkg.
module scfr_dp import scfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int MAX_START   = MAX_START_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scfr_cfg_t        cfg,
    input  scfr_cmd_t        cmd,
    output scfr_stat_t       stat,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [POS_W-1:0] out_pos,
    output logic             out_final,
    output logic             out_ok
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
    localparam int MC_W  = $clog2(MAX_START + 1);
    localparam int AW    = $clog2(MAX_PAYLOAD);

    // Effective lengths.
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] len_p1;
    logic [MC_W-1:0]  slen;

    // Hunt and collect state.
    logic [MC_W-1:0]  match_reg, match_next;
    logic [CNT_W-1:0] collect_reg, collect_next;
    logic [7:0]       overhead_reg, overhead_next;
    logic             collecting;
    logic             store_room;
    logic             store_we;
    logic [AW-1:0]    wr_addr;

    // Frame store.
    logic [7:0]       frame_mem [MAX_PAYLOAD];
    logic [7:0]       rdata_reg;
    logic [AW-1:0]    rd_addr;

    // Decode walker.
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [7:0]       remain_reg, remain_next;
    logic             prev_ff_reg, prev_ff_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       last_reg, last_next;
    logic             ok_reg, ok_next;
    logic [7:0]       enc_byte;
    logic             code_pos;
    logic             emit_raw;
    logic [7:0]       emit_byte;
    logic             is_last;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             out_final_reg;
    logic             out_ok_reg;
    logic             out_load;

    // Clamp the configured lengths.
    always_comb
    begin
        if (cfg.payload_length < PLEN_W'(MIN_PAYLOAD))
        begin
            len = CNT_W'(MIN_PAYLOAD);
        end
        else if (int'(cfg.payload_length) > MAX_PAYLOAD)
        begin
            len = CNT_W'(MAX_PAYLOAD);
        end
        else
        begin
            len = CNT_W'(cfg.payload_length);
        end
        if (int'(cfg.start_length) > MAX_START)
        begin
            slen = MC_W'(MAX_START);
        end
        else
        begin
            slen = MC_W'(cfg.start_length);
        end
    end

    assign len_p1     = len + CNT_W'(1);
    assign collecting = (match_reg == slen);
    assign store_room = (collect_reg < len_p1);
    assign wr_addr    = AW'(collect_reg - CNT_W'(1));

    // Hunt for the start sequence, then collect the encoded frame.
    always_comb
    begin
        match_next    = match_reg;
        collect_next  = collect_reg;
        overhead_next = overhead_reg;
        store_we      = 1'b0;
        if (cmd.take)
        begin
            if (collecting)
            begin
                if (store_room)
                begin
                    store_we     = 1'b1;
                    collect_next = collect_reg + CNT_W'(1);
                end
                else
                begin
                    match_next   = '0;
                    collect_next = CNT_W'(1);
                end
            end
            else if (match_reg < slen)
            begin
                if (in_byte == start_byte(cfg.start_pattern, int'(match_reg)))
                begin
                    match_next = match_reg + MC_W'(1);
                end
                else
                begin
                    // The mismatching byte, less the start length, becomes the COBS overhead byte.
                    overhead_next = in_byte - 8'(slen);
                    match_next    = '0;
                    collect_next  = CNT_W'(1);
                end
            end
            else
            begin
                // Start length was lowered under the hunt.
                match_next   = '0;
                collect_next = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= '0;
            collect_reg  <= CNT_W'(1);
            overhead_reg <= '0;
        end
        else
        begin
            match_reg    <= match_next;
            collect_reg  <= collect_next;
            overhead_reg <= overhead_next;
        end
    end

    // Frame store: one write port for collection, one registered read port.
    assign rd_addr = (r_reg == '0) ? '0 : AW'(r_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            frame_mem[wr_addr] <= in_byte;
        end
        rdata_reg <= frame_mem[rd_addr];
    end

    // One encoded position per step: a code byte or a data byte.
    assign enc_byte  = (r_reg == '0) ? overhead_reg : rdata_reg;
    assign code_pos  = (remain_reg == 8'h00);
    assign emit_raw  = code_pos ? !prev_ff_reg : 1'b1;
    assign emit_byte = code_pos ? FRAME_DELIM : enc_byte;
    assign is_last   = (w_reg == len - CNT_W'(1));

    always_comb
    begin
        r_next       = r_reg;
        w_next       = w_reg;
        remain_next  = remain_reg;
        prev_ff_next = prev_ff_reg;
        sum_next     = sum_reg;
        last_next    = last_reg;
        ok_next      = ok_reg;
        if (cmd.ok_load)
        begin
            ok_next = !cfg.checksum_enable || (sum_reg == last_reg);
        end
        if (cmd.walk_init)
        begin
            r_next       = '0;
            w_next       = '0;
            remain_next  = '0;
            prev_ff_next = 1'b1;
            sum_next     = '0;
            last_next    = '0;
        end
        else if (cmd.step)
        begin
            r_next = r_reg + CNT_W'(1);
            if (code_pos)
            begin
                // A zero code counts as one.
                remain_next  = (enc_byte == 8'h00) ? 8'h00 : enc_byte - 8'h01;
                prev_ff_next = (enc_byte == COBS_MAX_CODE);
            end
            else
            begin
                remain_next = remain_reg - 8'h01;
            end
            if (stat.emit_pending)
            begin
                w_next = w_reg + CNT_W'(1);
                if (cmd.sum_pass)
                begin
                    if (is_last)
                    begin
                        last_next = emit_byte;
                    end
                    else
                    begin
                        sum_next = sum_reg + emit_byte;
                    end
                end
            end
        end
        else if (cmd.tail_emit)
        begin
            w_next = w_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg       <= '0;
            w_reg       <= '0;
            remain_reg  <= '0;
            prev_ff_reg <= 1'b1;
            sum_reg     <= '0;
            last_reg    <= '0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            r_reg       <= r_next;
            w_reg       <= w_next;
            remain_reg  <= remain_next;
            prev_ff_reg <= prev_ff_next;
            sum_reg     <= sum_next;
            last_reg    <= last_next;
            ok_reg      <= ok_next;
        end
    end

    // Output register decouples emission from the consumer.
    assign out_load = (cmd.step && !cmd.sum_pass && stat.emit_pending) || cmd.tail_emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg  <= cmd.tail_emit ? FRAME_DELIM : emit_byte;
            out_pos_reg   <= POS_W'(w_reg);
            out_final_reg <= is_last;
            out_ok_reg    <= ok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_pos   = out_pos_reg;
    assign out_final = out_final_reg;
    assign out_ok    = out_ok_reg;

    // Status to the controller.
    assign stat.frame_good   = collecting && !store_room && (in_byte == FRAME_DELIM);
    assign stat.walk_done    = (r_reg > len);
    assign stat.w_full       = (w_reg >= len);
    assign stat.emit_pending = emit_raw && !stat.w_full;
    assign stat.out_free     = !out_valid_reg || out_ready;

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n) out_load |-> stat.out_free)
        else $error("output register overwritten");

    // The last mark sits on the last message position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_final_reg |-> out_pos_reg == POS_W'(len - CNT_W'(1)))
        else $error("final byte at wrong position");

    // Collection never runs past the frame store.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(collect_reg) <= MAX_PAYLOAD + 1)
        else $error("collect count out of range");

    // The walker only steps over positions of the encoded frame.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.step |-> r_reg <= len)
        else $error("decode walker past end of frame");

endmodule
